/* hw/rtl/arbitrary_axis_frame_defines.svh */
// Assertion macros shared by the arbitrary axis frame RTL.
`ifndef ARBITRARY_AXIS_FRAME_DEFINES_SVH
`define ARBITRARY_AXIS_FRAME_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define AFR_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("arbitrary_axis_frame: assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define AFR_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("arbitrary_axis_frame: assertion failed");

`endif

/* hw/rtl/afr_pkg.sv */
// Types and fixed-point constants for the arbitrary axis frame block.
package afr_pkg;

  // Unsigned magnitude after block shift, at most 2^31.
  typedef logic [31:0] mag_t;
  // Signed Q2.30 axis component.
  typedef logic signed [31:0] q30_t;

  localparam q30_t        ONE_Q30     = 32'sh4000_0000;
  localparam logic [31:0] SMALL_Q30   = 32'h0100_0000;
  localparam logic [63:0] MAG_LIMIT   = 64'h0000_0000_8000_0000;
  localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_2000_0000;
  localparam int          SQRT_STEPS  = 32;
  localparam int          DIV_STEPS   = 31;
  localparam int          SHIFT_W     = 6;
  localparam int          OUT_TDATA_W = 288;

  // Side data carried through the first normalizer.
  typedef struct packed {
    logic          use_ref;
    logic [2:0]    rneg;
    mag_t [2:0]    rmag;
  } side1_t;

  // Side data carried through the second normalizer.
  typedef struct packed {
    logic          degen;
    q30_t [2:0]    z;
  } side2_t;

endpackage

/* hw/rtl/afr_norm.sv */
// Pipelined vector normalizer: squares, sum, bit-by-bit square root, long division.
module afr_norm #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  afr_pkg::mag_t [2:0] in_mag,
  input  logic [2:0]          in_neg,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output afr_pkg::q30_t [2:0] out_unit,
  output logic                out_zero,
  output logic [SIDE_W-1:0]   out_side
);
  import afr_pkg::*;

  // Squares of the magnitudes.
  logic              sq_valid;
  logic [2:0][63:0]  sq_val;
  mag_t [2:0]        sq_mag;
  logic [2:0]        sq_neg;
  logic [SIDE_W-1:0] sq_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_val[i] <= 64'(in_mag[i]) * 64'(in_mag[i]);
      end
      sq_mag  <= in_mag;
      sq_neg  <= in_neg;
      sq_side <= in_side;
    end
  end

  // Sum of squares.
  logic              sm_valid;
  logic [63:0]       sm_sum;
  mag_t [2:0]        sm_mag;
  logic [2:0]        sm_neg;
  logic [SIDE_W-1:0] sm_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else if (en) begin
      sm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_sum  <= sq_val[0] + sq_val[1] + sq_val[2];
      sm_mag  <= sq_mag;
      sm_neg  <= sq_neg;
      sm_side <= sq_side;
    end
  end

  // Square root, one result bit per stage.
  logic              rt_valid [SQRT_STEPS+1];
  logic [63:0]       rt_n     [SQRT_STEPS+1];
  logic [63:0]       rt_r     [SQRT_STEPS+1];
  mag_t [2:0]        rt_mag   [SQRT_STEPS+1];
  logic [2:0]        rt_neg   [SQRT_STEPS+1];
  logic              rt_zero  [SQRT_STEPS+1];
  logic [SIDE_W-1:0] rt_side  [SQRT_STEPS+1];

  assign rt_valid[0] = sm_valid;
  assign rt_n[0]     = sm_sum;
  assign rt_r[0]     = '0;
  assign rt_mag[0]   = sm_mag;
  assign rt_neg[0]   = sm_neg;
  assign rt_zero[0]  = (sm_sum == '0);
  assign rt_side[0]  = sm_side;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_root
    localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    assign trial = rt_r[g] + RBIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_valid[g+1] <= 1'b0;
      end else if (en) begin
        rt_valid[g+1] <= rt_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_n[g] >= trial) begin
          rt_n[g+1] <= rt_n[g] - trial;
          rt_r[g+1] <= (rt_r[g] >> 1) + RBIT;
        end else begin
          rt_n[g+1] <= rt_n[g];
          rt_r[g+1] <= rt_r[g] >> 1;
        end
        rt_mag[g+1]  <= rt_mag[g];
        rt_neg[g+1]  <= rt_neg[g];
        rt_zero[g+1] <= rt_zero[g];
        rt_side[g+1] <= rt_side[g];
      end
    end
  end

  // Division setup: numerator is mag * 2^31 + L, denominator is 2 * L.
  logic [31:0] root_len;
  assign root_len = rt_r[SQRT_STEPS][31:0];

  logic              dv_valid [DIV_STEPS+1];
  logic [34:0]       dv_den   [DIV_STEPS+1];
  logic [2:0][34:0]  dv_rem   [DIV_STEPS+1];
  logic [2:0][30:0]  dv_low   [DIV_STEPS+1];
  logic [2:0][30:0]  dv_quo   [DIV_STEPS+1];
  logic [2:0]        dv_neg   [DIV_STEPS+1];
  logic              dv_zero  [DIV_STEPS+1];
  logic [SIDE_W-1:0] dv_side  [DIV_STEPS+1];

  logic [2:0][63:0] numer;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = (64'(rt_mag[SQRT_STEPS][i]) << 31) + 64'(root_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= rt_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_den[0] <= 35'({root_len, 1'b0});
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= 35'(numer[i] >> 31);
        dv_low[0][i] <= numer[i][30:0];
        dv_quo[0][i] <= '0;
      end
      dv_neg[0]  <= rt_neg[SQRT_STEPS];
      dv_zero[0] <= rt_zero[SQRT_STEPS];
      dv_side[0] <= rt_side[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit per stage for each component.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [2:0][34:0] trial;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dv_rem[g][i][33:0], dv_low[g][i][30]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else if (en) begin
        dv_valid[g+1] <= dv_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= dv_den[g]) begin
            dv_rem[g+1][i] <= trial[i] - dv_den[g];
            dv_quo[g+1][i] <= {dv_quo[g][i][29:0], 1'b1};
          end else begin
            dv_rem[g+1][i] <= trial[i];
            dv_quo[g+1][i] <= {dv_quo[g][i][29:0], 1'b0};
          end
          dv_low[g+1][i] <= {dv_low[g][i][29:0], 1'b0};
        end
        dv_den[g+1]  <= dv_den[g];
        dv_neg[g+1]  <= dv_neg[g];
        dv_zero[g+1] <= dv_zero[g];
        dv_side[g+1] <= dv_side[g];
      end
    end
  end

  // Clamp to one and restore the sign.
  q30_t [2:0] unit_mag;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, dv_quo[DIV_STEPS][i]} > ONE_Q30) begin
        unit_mag[i] = ONE_Q30;
      end else begin
        unit_mag[i] = {1'b0, dv_quo[DIV_STEPS][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_unit[i] <= dv_neg[DIV_STEPS][i] ? -unit_mag[i] : unit_mag[i];
      end
      out_zero <= dv_zero[DIV_STEPS];
      out_side <= dv_side[DIV_STEPS];
    end
  end

endmodule

/* hw/rtl/arbitrary_axis_frame.sv */
// Arbitrary axis frame: a fully pipelined unit that turns one direction beat into a local
// frame. It takes a new beat every cycle while m_tready is high; a result passes through
// two normalizers of 67 stages each, plus input, reference, helper, cross-product and output
// stages, and the whole pipeline holds while the output register waits. The z axis is
// the normalized direction, flipped when s_tuser asks for the reference test and the
// reference points away. The x axis is the normalized helper cross z, and y is z cross
// x; all axes are signed Q2.30. A zero direction gives all-zero axes with m_tuser set.
`include "arbitrary_axis_frame_defines.svh"

module arbitrary_axis_frame #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // dir_x, dir_y, dir_z, ref_x, ref_y, ref_z (COORD_WIDTH each), zero fill
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  // use_ref
  input  logic [0:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // axis_x_x, axis_x_y, axis_x_z, axis_y_x, axis_y_y, axis_y_z,
  // axis_z_x, axis_z_y, axis_z_z (32 bits each)
  output logic [afr_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // degenerate
  output logic [0:0]                              m_tuser
);
  import afr_pkg::*;

  localparam int SHIFT_MAX = (COORD_WIDTH > 32) ? COORD_WIDTH - 32 : 0;

  // The whole pipeline moves when the output register is free or being taken.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Input stage: magnitudes and signs.
  logic              p1_valid;
  logic [2:0][63:0]  p1_dmag;
  logic [2:0][63:0]  p1_rmag;
  logic [2:0]        p1_dneg;
  logic [2:0]        p1_rneg;
  logic              p1_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_dneg[i] <= s_tdata[i*COORD_WIDTH + COORD_WIDTH-1];
        p1_rneg[i] <= s_tdata[(i+3)*COORD_WIDTH + COORD_WIDTH-1];
        p1_dmag[i] <= s_tdata[i*COORD_WIDTH + COORD_WIDTH-1]
                    ? -64'($signed(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]))
                    : 64'($signed(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]));
        p1_rmag[i] <= s_tdata[(i+3)*COORD_WIDTH + COORD_WIDTH-1]
                    ? -64'($signed(s_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH]))
                    : 64'($signed(s_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH]));
      end
      p1_use <= s_tuser[0];
    end
  end

  // Block shift so that the largest magnitude is at most 2^31.
  logic [63:0]        dmax, rmax;
  logic [SHIFT_W-1:0] dsh, rsh;
  always_comb begin
    dmax = p1_dmag[0];
    rmax = p1_rmag[0];
    for (int i = 1; i < 3; i++) begin
      if (p1_dmag[i] > dmax) begin
        dmax = p1_dmag[i];
      end
      if (p1_rmag[i] > rmax) begin
        rmax = p1_rmag[i];
      end
    end
    dsh = '0;
    rsh = '0;
    for (int k = SHIFT_MAX; k >= 0; k--) begin
      if ((dmax >> k) <= MAG_LIMIT) begin
        dsh = SHIFT_W'(k);
      end
      if ((rmax >> k) <= MAG_LIMIT) begin
        rsh = SHIFT_W'(k);
      end
    end
  end

  logic        p2_valid;
  mag_t [2:0]  p2_dmag;
  logic [2:0]  p2_dneg;
  side1_t      p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p2_dmag[i]      <= 32'(p1_dmag[i] >> dsh);
        p2_side.rmag[i] <= 32'(p1_rmag[i] >> rsh);
      end
      p2_dneg         <= p1_dneg;
      p2_side.rneg    <= p1_rneg;
      p2_side.use_ref <= p1_use;
    end
  end

  // First normalizer gives the z axis.
  logic       n1_valid;
  q30_t [2:0] n1_z;
  logic       n1_zero;
  side1_t     n1_side;

  afr_norm #(
    .SIDE_W($bits(side1_t))
  ) u_norm_z (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (p2_valid),
    .in_mag   (p2_dmag),
    .in_neg   (p2_dneg),
    .in_side  (p2_side),
    .out_valid(n1_valid),
    .out_unit (n1_z),
    .out_zero (n1_zero),
    .out_side (n1_side)
  );

  // Reference dot product terms.
  logic signed [32:0] rc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc[i] = n1_side.rneg[i] ? -$signed({1'b0, n1_side.rmag[i]})
                              : $signed({1'b0, n1_side.rmag[i]});
    end
  end

  logic                    d1_valid;
  logic signed [2:0][63:0] d1_prod;
  q30_t [2:0]              d1_z;
  logic                    d1_degen;
  logic                    d1_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else if (adv) begin
      d1_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_prod[i] <= 64'(n1_z[i]) * 64'(rc[i]);
      end
      d1_z     <= n1_z;
      d1_degen <= n1_zero;
      d1_use   <= n1_side.use_ref;
    end
  end

  // Flip z when the reference points the opposite way.
  logic signed [63:0] dot;
  assign dot = $signed(d1_prod[0]) + $signed(d1_prod[1]) + $signed(d1_prod[2]);

  logic       d2_valid;
  q30_t [2:0] d2_z;
  logic       d2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid <= 1'b0;
    end else if (adv) begin
      d2_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d2_z[i] <= (d1_use && dot < 0) ? -d1_z[i] : d1_z[i];
      end
      d2_degen <= d1_degen;
    end
  end

  // Helper axis cross z, as magnitudes and signs.
  q30_t [2:0] az;
  logic       small_xy;
  mag_t [2:0] hmag;
  logic [2:0] hneg;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      az[i] = d2_z[i][31] ? -d2_z[i] : d2_z[i];
    end
    small_xy = (az[0] < SMALL_Q30) && (az[1] < SMALL_Q30);
    if (small_xy) begin
      hmag[0] = az[2];
      hneg[0] = 1'b0;
      hmag[1] = '0;
      hneg[1] = 1'b0;
      hmag[2] = az[0];
      hneg[2] = (d2_z[2] > 0) ? (d2_z[0] > 0) : d2_z[0][31];
    end else begin
      hmag[0] = az[1];
      hneg[0] = !d2_z[2][31] ? (d2_z[1] > 0) : d2_z[1][31];
      hmag[1] = az[0];
      hneg[1] = !d2_z[2][31] ? d2_z[0][31] : (d2_z[0] > 0);
      hmag[2] = '0;
      hneg[2] = 1'b0;
    end
  end

  logic       d3_valid;
  mag_t [2:0] d3_hmag;
  logic [2:0] d3_hneg;
  side2_t     d3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_valid <= 1'b0;
    end else if (adv) begin
      d3_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_hmag       <= hmag;
      d3_hneg       <= hneg;
      d3_side.z     <= d2_z;
      d3_side.degen <= d2_degen;
    end
  end

  // Second normalizer gives the x axis.
  logic       n2_valid;
  q30_t [2:0] n2_x;
  logic       n2_zero;
  side2_t     n2_side;

  afr_norm #(
    .SIDE_W($bits(side2_t))
  ) u_norm_x (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (d3_valid),
    .in_mag   (d3_hmag),
    .in_neg   (d3_hneg),
    .in_side  (d3_side),
    .out_valid(n2_valid),
    .out_unit (n2_x),
    .out_zero (n2_zero),
    .out_side (n2_side)
  );

  // A zero helper gives a zero x axis.
  q30_t [2:0] xa;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xa[i] = n2_zero ? '0 : n2_x[i];
    end
  end

  // Cross product terms for y = z cross x.
  logic                    c1_valid;
  logic signed [5:0][63:0] c1_p;
  q30_t [2:0]              c1_x;
  q30_t [2:0]              c1_z;
  logic                    c1_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (adv) begin
      c1_valid <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_p[0]  <= 64'(n2_side.z[1]) * 64'(xa[2]);
      c1_p[1]  <= 64'(n2_side.z[2]) * 64'(xa[1]);
      c1_p[2]  <= 64'(n2_side.z[2]) * 64'(xa[0]);
      c1_p[3]  <= 64'(n2_side.z[0]) * 64'(xa[2]);
      c1_p[4]  <= 64'(n2_side.z[0]) * 64'(xa[1]);
      c1_p[5]  <= 64'(n2_side.z[1]) * 64'(xa[0]);
      c1_x     <= xa;
      c1_z     <= n2_side.z;
      c1_degen <= n2_side.degen;
    end
  end

  // Differences in Q4.60.
  logic                    c2_valid;
  logic signed [2:0][63:0] c2_diff;
  q30_t [2:0]              c2_x;
  q30_t [2:0]              c2_z;
  logic                    c2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (adv) begin
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c2_diff[i] <= $signed(c1_p[2*i]) - $signed(c1_p[2*i+1]);
      end
      c2_x     <= c1_x;
      c2_z     <= c1_z;
      c2_degen <= c1_degen;
    end
  end

  // Round to Q2.30 half away from zero, saturate.
  q30_t [2:0]  ya;
  logic [63:0] dmag_r [3];
  logic [63:0] rnd    [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag_r[i] = c2_diff[i][63] ? -c2_diff[i] : c2_diff[i];
      rnd[i]    = (dmag_r[i] + ROUND_HALF) >> 30;
      if (rnd[i] > 64'(ONE_Q30)) begin
        ya[i] = ONE_Q30;
      end else begin
        ya[i] = q30_t'(rnd[i][31:0]);
      end
      if (c2_diff[i][63]) begin
        ya[i] = -ya[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c2_degen) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {c2_z[2], c2_z[1], c2_z[0], ya[2], ya[1], ya[0],
                    c2_x[2], c2_x[1], c2_x[0]};
      end
      m_tuser[0] <= c2_degen;
    end
  end

  // The z component of the local z axis as it leaves the block.
  q30_t out_zz;
  assign out_zz = m_tdata[287:256];

  // A degenerate result carries all-zero axes.
  `AFR_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == '0)
  // The z component of the z axis stays within plus and minus one.
  `AFR_ASSERT_NOW(a_zz_range, m_tvalid, (out_zz <= ONE_Q30) && (out_zz >= -ONE_Q30))
  // A stalled output holds the pipeline's last stage as well.
  `AFR_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, $stable(c2_diff) && $stable(c2_valid))

endmodule
